/* hw/rtl/fcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fcs_pkg;

	// Wait ring geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Field widths
	localparam int ID_W     = 8;
	localparam int PERMIT_W = 8;
	localparam int STATUS_W = 3;

	localparam logic [PERMIT_W-1:0] PERMIT_MAX       = '1;
	localparam logic [PERMIT_W-1:0] PERMIT_RST_VALUE = PERMIT_W'(3);

	// Request commands
	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED   = 3'd0,
		ST_QUEUED    = 3'd1,
		ST_FULL      = 3'd2,
		ST_WOKE      = 3'd3,
		ST_ADDED     = 3'd4,
		ST_SATURATED = 3'd5
	} status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/fcs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module fcs_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	output logic             done,
	output fcs_pkg::ctrl_cmd_t cmd_o
);
	import fcs_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	// Hold state and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) state_q <= S_EXEC;
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q == S_EXEC);
	assign done       = done_q;
	assign cmd_o.load = (state_q == S_IDLE) && start;
	assign cmd_o.exec = (state_q == S_EXEC);

endmodule

`default_nettype wire

/* hw/rtl/fcs_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module fcs_dp (
	input  wire                           clk,
	input  wire                           arst_n,
	input  fcs_pkg::ctrl_cmd_t            cmd_i,
	input  wire                           cmd,
	input  wire  [fcs_pkg::ID_W-1:0]      requester_id,
	input  wire                           cfg_we,
	input  wire  [fcs_pkg::PERMIT_W-1:0]  cfg_wdata,
	output logic [fcs_pkg::STATUS_W-1:0]  status,
	output logic [fcs_pkg::ID_W-1:0]      woken_id,
	output logic [fcs_pkg::PERMIT_W-1:0]  permits_now,
	output logic [fcs_pkg::CNT_W-1:0]     waiters_now
);
	import fcs_pkg::*;

	// Latched transaction
	logic            cmd_q;
	logic [ID_W-1:0] id_q;

	// Semaphore state
	logic [PERMIT_W-1:0] permits_q;
	logic [IDX_W-1:0]    head_q;
	logic [IDX_W-1:0]    tail_q;
	logic [CNT_W-1:0]    count_q;

	// Wait ring and its registered read port
	logic [ID_W-1:0] ring_mem [QUEUE_DEPTH];
	logic [ID_W-1:0] rd_data_q;

	// Result registers
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     woken_q;
	logic [PERMIT_W-1:0] permits_out_q;
	logic [CNT_W-1:0]    waiters_out_q;

	// Next-state values
	logic [PERMIT_W-1:0] permits_d;
	logic [IDX_W-1:0]    head_d;
	logic [IDX_W-1:0]    tail_d;
	logic [CNT_W-1:0]    count_d;
	status_t             status_d;
	logic [ID_W-1:0]     woken_d;
	logic                ring_we;
	logic [IDX_W-1:0]    head_inc;
	logic [IDX_W-1:0]    tail_inc;

	// Advance ring pointers with wrap at the ring depth
	assign head_inc = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
	assign tail_inc = (tail_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + IDX_W'(1);

	// Decide the outcome of the latched request
	always_comb begin
		permits_d = permits_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		woken_d   = '0;
		ring_we   = 1'b0;
		status_d  = ST_GRANTED;
		if (cmd_q == CMD_ACQUIRE) begin
			if (permits_q != '0) begin
				permits_d = permits_q - PERMIT_W'(1);
				status_d  = ST_GRANTED;
			end else if (count_q != CNT_W'(QUEUE_DEPTH)) begin
				ring_we  = 1'b1;
				tail_d   = tail_inc;
				count_d  = count_q + CNT_W'(1);
				status_d = ST_QUEUED;
			end else begin
				status_d = ST_FULL;
			end
		end else begin
			if (count_q != '0) begin
				woken_d  = rd_data_q;
				head_d   = head_inc;
				count_d  = count_q - CNT_W'(1);
				status_d = ST_WOKE;
			end else if (permits_q != PERMIT_MAX) begin
				permits_d = permits_q + PERMIT_W'(1);
				status_d  = ST_ADDED;
			end else begin
				status_d = ST_SATURATED;
			end
		end
	end

	// Hold semaphore state; a register write reloads permits and empties the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			permits_q <= PERMIT_RST_VALUE;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
		end else if (cfg_we) begin
			permits_q <= cfg_wdata;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
		end else if (cmd_i.exec) begin
			permits_q <= permits_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
		end
	end

	// Latch the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			cmd_q <= cmd;
			id_q  <= requester_id;
		end
	end

	// Write at the tail, read the oldest waiter every cycle
	always_ff @(posedge clk) begin
		if (cmd_i.exec && ring_we) ring_mem[tail_q] <= id_q;
		rd_data_q <= ring_mem[head_q];
	end

	// Register the result
	always_ff @(posedge clk) begin
		if (cmd_i.exec) begin
			status_q      <= status_d;
			woken_q       <= woken_d;
			permits_out_q <= permits_d;
			waiters_out_q <= count_d;
		end
	end

	assign status      = status_q;
	assign woken_id    = woken_q;
	assign permits_now = permits_out_q;
	assign waiters_now = waiters_out_q;

endmodule

`default_nettype wire

/* hw/rtl/fifo_counting_semaphore_core.sv */
// Channel   Signals                                        Handshake
// request   cmd, requester_id                              start && !busy
// result    status, woken_id, permits_now, waiters_now     done, one cycle
// config    cfg_wdata (initial permits)                    cfg_we
//
// Each request is latched when it is accepted in S_IDLE; the S_EXEC state
// then updates the semaphore and registers the result together with done.
// A new request can be accepted in the cycle done is high.
// Reset loads three permits and empties the wait queue.
// The receiver cannot stall; a new request is not accepted while the update
// in S_EXEC is under way (busy high).
`timescale 1ns / 1ps
`default_nettype none

module fifo_counting_semaphore_core (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  wire                           cmd,
	input  wire  [fcs_pkg::ID_W-1:0]      requester_id,
	input  wire                           cfg_we,
	input  wire  [fcs_pkg::PERMIT_W-1:0]  cfg_wdata,
	output logic                          done,
	output logic [fcs_pkg::STATUS_W-1:0]  status,
	output logic [fcs_pkg::ID_W-1:0]      woken_id,
	output logic [fcs_pkg::PERMIT_W-1:0]  permits_now,
	output logic [fcs_pkg::CNT_W-1:0]     waiters_now
);
	import fcs_pkg::*;

	ctrl_cmd_t ctrl_cmd;

	// Sequence each transaction
	fcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd_o  (ctrl_cmd)
	);

	// Hold the count, the wait ring and the result
	fcs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_i        (ctrl_cmd),
		.cmd          (cmd),
		.requester_id (requester_id),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.status       (status),
		.woken_id     (woken_id),
		.permits_now  (permits_now),
		.waiters_now  (waiters_now)
	);

endmodule

`default_nettype wire

/* hw/rtl/fcs_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module fcs_chk (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           start,
	input wire                           busy,
	input wire                           done,
	input wire [fcs_pkg::STATUS_W-1:0]   status,
	input wire [fcs_pkg::ID_W-1:0]       woken_id,
	input wire [fcs_pkg::CNT_W-1:0]      waiters_now
);
	import fcs_pkg::*;

	// An accepted transaction is worked on in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// Work ends in a result in the next cycle, with busy low again
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("busy cycle not followed by a result");

	// A result only follows work
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a transaction");

	// Woken id is zero unless a waiter was woken
	a_woken_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_WOKE) |-> woken_id == '0)
		else $error("woken id set without a wake");

	// Waiter count stays within the ring
	a_waiters_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> waiters_now <= CNT_W'(QUEUE_DEPTH))
		else $error("waiter count beyond ring depth");

endmodule

bind fifo_counting_semaphore_core fcs_chk u_fcs_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.woken_id    (woken_id),
	.waiters_now (waiters_now)
);

`default_nettype wire

/* verif/semaphore_result_checker.sv */
`timescale 1ns / 1ps

module semaphore_result_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire                          busy,
	input  wire                          cmd,
	input  wire  [fcs_pkg::ID_W-1:0]     requester_id,
	input  wire                          cfg_we,
	input  wire  [fcs_pkg::PERMIT_W-1:0] cfg_wdata,
	input  wire                          done,
	input  wire  [fcs_pkg::STATUS_W-1:0] status,
	input  wire  [fcs_pkg::ID_W-1:0]     woken_id,
	input  wire  [fcs_pkg::PERMIT_W-1:0] permits_now,
	input  wire  [fcs_pkg::CNT_W-1:0]    waiters_now,
	output int                           pending,
	output int                           fails,
	output int                           n_checked,
	output int                           n_woke,
	output int                           n_full,
	output int                           n_saturated
);
	import fcs_pkg::*;

	typedef struct packed {
		status_t             status;
		logic [ID_W-1:0]     woken;
		logic [PERMIT_W-1:0] permits;
		logic [CNT_W-1:0]    waiters;
	} sem_outcome_t;

	// Own copy of the semaphore state
	logic [PERMIT_W-1:0] free_permits;
	logic [ID_W-1:0]     waiter_ids [QUEUE_DEPTH];
	logic [IDX_W-1:0]    oldest_slot;
	logic [IDX_W-1:0]    next_slot;
	logic [CNT_W-1:0]    waiter_cnt;

	sem_outcome_t outcomes_due [$];

	initial begin
		pending     = 0;
		fails       = 0;
		n_checked   = 0;
		n_woke      = 0;
		n_full      = 0;
		n_saturated = 0;
	end

	task automatic report(string msg);
		$display("ERROR %0t ns: %s", $time, msg);
		fails++;
	endtask

	// Advance the semaphore by one request and give the outcome it produces
	function automatic sem_outcome_t next_semaphore_outcome(logic op, logic [ID_W-1:0] id);
		sem_outcome_t r;
		r.woken = '0;
		if (op == CMD_ACQUIRE) begin
			if (free_permits != '0) begin
				free_permits = free_permits - 1'b1;
				r.status = ST_GRANTED;
			end else if (waiter_cnt < QUEUE_DEPTH) begin
				waiter_ids[next_slot] = id;
				next_slot  = next_slot + 1'b1;
				waiter_cnt = waiter_cnt + 1'b1;
				r.status = ST_QUEUED;
			end else begin
				r.status = ST_FULL;
			end
		end else begin
			if (waiter_cnt != '0) begin
				r.woken     = waiter_ids[oldest_slot];
				oldest_slot = oldest_slot + 1'b1;
				waiter_cnt  = waiter_cnt - 1'b1;
				r.status = ST_WOKE;
			end else if (free_permits != PERMIT_MAX) begin
				free_permits = free_permits + 1'b1;
				r.status = ST_ADDED;
			end else begin
				r.status = ST_SATURATED;
			end
		end
		r.permits = free_permits;
		r.waiters = waiter_cnt;
		return r;
	endfunction

	task automatic compare_outcome(sem_outcome_t exp);
		if (status !== exp.status)
			report($sformatf("status expected %0d, got %0d", exp.status, status));
		if (woken_id !== exp.woken)
			report($sformatf("woken_id expected %0d, got %0d", exp.woken, woken_id));
		if (permits_now !== exp.permits)
			report($sformatf("permits_now expected %0d, got %0d", exp.permits, permits_now));
		if (waiters_now !== exp.waiters)
			report($sformatf("waiters_now expected %0d, got %0d", exp.waiters, waiters_now));
		case (exp.status)
			ST_WOKE:      n_woke++;
			ST_FULL:      n_full++;
			ST_SATURATED: n_saturated++;
			default: ;
		endcase
		n_checked++;
	endtask

	// Retire results first, then apply register writes and new transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_permits = PERMIT_RST_VALUE;
			oldest_slot  = '0;
			next_slot    = '0;
			waiter_cnt   = '0;
			outcomes_due.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (outcomes_due.size() == 0)
					report("result strobe with no transaction outstanding");
				else
					compare_outcome(outcomes_due.pop_front());
			end
			if (cfg_we) begin
				free_permits = cfg_wdata;
				oldest_slot  = '0;
				next_slot    = '0;
				waiter_cnt   = '0;
			end
			if (start && !busy)
				outcomes_due.push_back(next_semaphore_outcome(cmd, requester_id));
			pending <= outcomes_due.size();
		end
	end

endmodule

/* verif/fifo_counting_semaphore_core_test.sv */
`timescale 1ns / 1ps

module fifo_counting_semaphore_core_test;

	import fcs_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int ITEM_TARGET = 1325;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic                cmd          = CMD_ACQUIRE;
	logic [ID_W-1:0]     requester_id = '0;
	logic                cfg_we       = 1'b0;
	logic [PERMIT_W-1:0] cfg_wdata    = '0;

	wire                busy;
	wire                done;
	wire [STATUS_W-1:0] status;
	wire [ID_W-1:0]     woken_id;
	wire [PERMIT_W-1:0] permits_now;
	wire [CNT_W-1:0]    waiters_now;

	int pending;
	int chk_fails;
	int n_checked;
	int n_woke;
	int n_full;
	int n_saturated;

	int n_acquires = 0;
	int n_releases = 0;
	int n_writes   = 0;

	always #2 clk = ~clk;

	fifo_counting_semaphore_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.requester_id (requester_id),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.status       (status),
		.woken_id     (woken_id),
		.permits_now  (permits_now),
		.waiters_now  (waiters_now)
	);

	semaphore_result_checker result_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.requester_id (requester_id),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.status       (status),
		.woken_id     (woken_id),
		.permits_now  (permits_now),
		.waiters_now  (waiters_now),
		.pending      (pending),
		.fails        (chk_fails),
		.n_checked    (n_checked),
		.n_woke       (n_woke),
		.n_full       (n_full),
		.n_saturated  (n_saturated)
	);

	// Present one request and hold it until the core takes it; start stays high
	task automatic send_request(logic op, logic [ID_W-1:0] id);
		start        <= 1'b1;
		cmd          <= op;
		requester_id <= id;
		do @(posedge clk); while (busy);
		if (op == CMD_ACQUIRE)
			n_acquires++;
		else
			n_releases++;
	endtask

	task automatic idle_for(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Mostly back to back, sometimes short gaps, rarely long ones
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Drain all outstanding transactions, then load a new permit count
	task automatic write_permits(logic [PERMIT_W-1:0] value);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_writes++;
	endtask

	function automatic logic [PERMIT_W-1:0] pick_permits();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return PERMIT_W'($urandom_range(0, 3));
		else if (sel == 4)
			return '0;
		else if (sel == 5)
			return PERMIT_MAX;
		else if (sel == 6)
			return PERMIT_W'($urandom_range(250, 255));
		return PERMIT_W'($urandom_range(0, 255));
	endfunction

	initial begin
		int  acq_pct;
		int  burst;
		int  gap;
		int  waited;
		int  leftover;
		bit  no_gaps;
		logic op;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Use up the three permits from reset, fill the ring, then overflow it
		for (int i = 0; i < 3; i++)
			send_request(CMD_ACQUIRE, ID_W'(i));
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			case (i)
				0:       send_request(CMD_ACQUIRE, 8'h00);
				1:       send_request(CMD_ACQUIRE, 8'hFF);
				2:       send_request(CMD_ACQUIRE, 8'hAA);
				3:       send_request(CMD_ACQUIRE, 8'h55);
				default: send_request(CMD_ACQUIRE, ID_W'($urandom_range(0, 255)));
			endcase
		end
		send_request(CMD_ACQUIRE, 8'h5A);
		send_request(CMD_RELEASE, 8'h00);

		// Reload with waiters still queued, then hit the saturation ceiling
		write_permits(PERMIT_MAX);
		send_request(CMD_RELEASE, 8'hFF);
		send_request(CMD_ACQUIRE, 8'h3C);
		send_request(CMD_RELEASE, 8'hC3);
		write_permits('0);
		send_request(CMD_RELEASE, 8'h81);

		// Random phases, each with its own permit load, mix and pacing
		while (n_acquires + n_releases < ITEM_TARGET) begin
			write_permits(pick_permits());
			acq_pct = $urandom_range(20, 80);
			burst   = $urandom_range(20, 90);
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < burst; k++) begin
				op = ($urandom_range(0, 99) < acq_pct) ? CMD_ACQUIRE : CMD_RELEASE;
				send_request(op, ID_W'($urandom_range(0, 255)));
				if (!no_gaps) begin
					gap = gap_length();
					if (gap != 0)
						idle_for(gap);
				end
			end
		end

		// Wait for the last results, with a bound
		start <= 1'b0;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending != 0 && waited < 500);
		repeat (4) @(posedge clk);
		leftover = pending;
		if (leftover != 0)
			$display("ERROR: %0d transactions never produced a result", leftover);

		$display("Sent %0d acquires and %0d releases under %0d permit loads; %0d results checked.",
			n_acquires, n_releases, n_writes, n_checked);
		$display("Seen: %0d wakes, %0d ring-full rejects, %0d saturated releases.",
			n_woke, n_full, n_saturated);
		if (chk_fails == 0 && leftover == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Stop a hung run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

endmodule
